/* hw/rtl/sha384_pkg.sv */
package sha384_pkg;

  localparam logic [63:0] K_TABLE [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [63:0] IV_TABLE [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };

  localparam int QUEUE_DEPTH = 2;

  // queued item between front and back
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } sha384_item_t;

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    ror64 = (x >> n) | (x << (64 - n));
  endfunction

endpackage

/* hw/rtl/sha384_front.sv */
module sha384_front
  import sha384_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s_valid,
  output logic         s_ready,
  input  sha384_item_t s_item,
  output logic         q_valid,
  input  logic         q_ready,
  output sha384_item_t q_item
);

  sha384_item_t mem_r [QUEUE_DEPTH];
  logic wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  sha384_item_t clean;
  logic push, pop;

  // non-last beats are full words, counts above eight saturate
  always_comb begin
    clean = s_item;
    if (!s_item.last || s_item.nbytes > 4'd8) clean.nbytes = 4'd8;
  end

  assign s_ready = (cnt_r != 2'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rd_ptr_r];
  assign push    = s_valid && s_ready;
  assign pop     = q_valid && q_ready;
  assign wr_ptr_nxt = wr_ptr_r ^ push;
  assign rd_ptr_nxt = rd_ptr_r ^ pop;
  assign cnt_nxt = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= clean;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'(QUEUE_DEPTH) |-> !push) else $error("push into full queue");
  a_nbytes: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> q_item.nbytes <= 4'd8) else $error("unsaturated count");

endmodule

/* hw/rtl/sha384_back.sv */
module sha384_back
  import sha384_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  output logic         q_ready,
  input  sha384_item_t q_item,
  output logic         o_valid,
  input  logic         o_ready,
  output logic [63:0]  o_word,
  output logic [2:0]   o_index,
  output logic         o_last
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PAD  = 6'b000010,
    S_RUN  = 6'b000100,
    S_ADD  = 6'b001000,
    S_OUT  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [63:0] buf_r [16];
  logic [63:0] w_r [16];
  logic [63:0] h_r [8];
  logic [63:0] v_r [8];
  logic [3:0]  fill_r;
  logic [63:0] len_lo_r;
  logic [63:0] len_hi_r;
  logic [6:0]  rnd_r;
  logic [2:0]  oidx_r;
  // padding flow: pad_r 0 none, 1 data block before pad, 2 first pad block, 3 final
  logic [1:0]  pad_r;
  logic [6:0]  pos_r;
  logic [63:0] flen_lo_r, flen_hi_r;

  logic [63:0] big1, big0, ch, maj, t1, s0, s1, w_new;
  logic [63:0] mask, wmasked;
  logic [7:0]  pos_c;
  logic [63:0] lo_c;

  always_comb begin
    big1 = ror64(v_r[4], 14) ^ ror64(v_r[4], 18) ^ ror64(v_r[4], 41);
    ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1   = v_r[7] + big1 + ch + K_TABLE[rnd_r] + w_r[0];
    big0 = ror64(v_r[0], 28) ^ ror64(v_r[0], 34) ^ ror64(v_r[0], 39);
    maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    s0   = ror64(w_r[1], 1) ^ ror64(w_r[1], 8) ^ (w_r[1] >> 7);
    s1   = ror64(w_r[14], 19) ^ ror64(w_r[14], 61) ^ (w_r[14] >> 6);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    if (q_item.nbytes == 4'd0) mask = '0;
    else mask = ~(64'hffff_ffff_ffff_ffff >> (7'(q_item.nbytes) * 7'd8)) ;
    if (q_item.nbytes == 4'd8) mask = '1;
    wmasked = q_item.word & mask;
    pos_c = {1'b0, fill_r, 3'b000} + 8'(q_item.nbytes);
    lo_c  = len_lo_r + {53'd0, pos_c, 3'b000};
  end

  assign q_ready = (state_r == S_IDLE);
  assign o_valid = (state_r == S_OUT);
  assign o_word  = h_r[oidx_r];
  assign o_index = oidx_r;
  assign o_last  = (oidx_r == 3'd5);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (q_valid) begin
        if (!q_item.last) state_nxt = (fill_r == 4'd15) ? S_RUN : S_IDLE;
        else state_nxt = S_PAD;
      end
      S_PAD:  state_nxt = S_RUN;
      S_RUN:  if (rnd_r == 7'd79) state_nxt = S_ADD;
      S_ADD: begin
        if (pad_r == 2'd0) state_nxt = S_IDLE;
        else if (pad_r == 2'd1 || (pad_r == 2'd2 && pos_r >= 7'd112)) state_nxt = S_PAD;
        else state_nxt = S_OUT;
      end
      S_OUT:  if (o_ready && oidx_r == 3'd5) state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (q_valid) begin
        buf_r[fill_r] <= q_item.last ? wmasked : q_item.word;
        pos_r <= pos_c[6:0];
        if (q_item.last) begin
          flen_lo_r <= lo_c;
          flen_hi_r <= len_hi_r + 64'(lo_c < len_lo_r);
        end
        if (!q_item.last && fill_r == 4'd15) begin
          for (int i = 0; i < 16; i++) w_r[i] <= (i == 15) ? q_item.word : buf_r[i];
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        end
      end
      S_PAD: begin
        // builds the next block to compress from buf_r and pos_r, or from the stored message length
        if (pad_r == 2'd1) begin
          for (int i = 0; i < 16; i++) w_r[i] <= buf_r[i];
        end else if (pad_r == 2'd2) begin
          for (int i = 0; i < 16; i++) begin
            if (pos_r < 7'd112 && i == 14) w_r[i] <= flen_hi_r;
            else if (pos_r < 7'd112 && i == 15) w_r[i] <= flen_lo_r;
            else if (4'(i) < pos_r[6:3]) w_r[i] <= buf_r[i];
            else if (4'(i) == pos_r[6:3]) begin
              // a word boundary starts a fresh word, otherwise the marker joins the data
              if (pos_r[2:0] == 3'd0) w_r[i] <= 64'h80 << 56;
              else w_r[i] <= buf_r[i] | (64'h80 << (7'd56 - {1'b0, pos_r[2:0], 3'b000}));
            end else w_r[i] <= '0;
          end
        end else begin
          for (int i = 0; i < 14; i++) w_r[i] <= '0;
          w_r[14] <= flen_hi_r;
          w_r[15] <= flen_lo_r;
        end
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end
      S_RUN: begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= w_new;
        v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
        v_r[0] <= t1 + big0 + maj;
      end
      S_ADD: begin
        if (pad_r == 2'd1) pos_r <= 7'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= '0;
      len_lo_r <= '0;
      len_hi_r <= '0;
      rnd_r    <= '0;
      oidx_r   <= '0;
      pad_r    <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= IV_TABLE[i];
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: if (q_valid) begin
          rnd_r <= '0;
          if (!q_item.last) begin
            fill_r <= fill_r + 4'd1;
            if (fill_r == 4'd15) {len_hi_r, len_lo_r} <= {len_hi_r, len_lo_r} + 128'd1024;
          end else begin
            pad_r <= pos_c[7] ? 2'd1 : 2'd2;
          end
        end
        S_RUN: rnd_r <= rnd_r + 7'd1;
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          rnd_r <= '0;
          // a pad block with pos_r at 112 or more is followed by a length-only block
          if (pad_r == 2'd1) pad_r <= 2'd2;
          else if (pad_r == 2'd2) pad_r <= 2'd3;
        end
        S_OUT: if (o_ready) oidx_r <= oidx_r + 3'd1;
        S_DONE: begin
          oidx_r <= '0;
          fill_r <= '0;
          len_lo_r <= '0;
          len_hi_r <= '0;
          pad_r <= '0;
          for (int i = 0; i < 8; i++) h_r[i] <= IV_TABLE[i];
        end
        default: ;
      endcase
    end
  end

  a_out_idx: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid |-> oidx_r <= 3'd5) else $error("digest index out of range");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> !q_ready) else $error("accept during compression");
  a_round: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD |-> $past(rnd_r) == 7'd79) else $error("short compression");

endmodule

/* hw/rtl/sha384_stream_hasher.sv */
// with the sink ready, the first digest word of a last beat that finds the engine idle
// is offered after S_PAD, S_RUN and S_ADD, run twice when padding needs a second block
// non-last beats are taken while the engine is idle; each 16th beat stalls the input for
// a compression of one SHA-512 round per cycle; a two-entry queue feeds the engine
// reset (rst_n low, synchronous) loads the SHA-384 initial value and clears counters
module sha384_stream_hasher
  import sha384_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // message_word[63:0], valid_bytes[67:64], zeros
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // digest_word
  output logic [2:0]  out_tuser, // word_index
  output logic        out_tlast
);

  sha384_item_t s_item, q_item;
  logic q_valid, q_ready;

  assign s_item.word   = in_tdata[63:0];
  assign s_item.nbytes = in_tdata[67:64];
  assign s_item.last   = in_tlast;

  sha384_front u_front (
    .clk(clk), .rst_n(rst_n),
    .s_valid(in_tvalid), .s_ready(in_tready), .s_item(s_item),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  sha384_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .o_valid(out_tvalid), .o_ready(out_tready),
    .o_word(out_tdata), .o_index(out_tuser), .o_last(out_tlast)
  );

endmodule

/* verif/sha384_digest_checker.sv */
module sha384_digest_checker
  import sha384_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  output int          error_count,
  output int          pending_words
);

  typedef struct packed {
    logic [63:0] word;
    logic [2:0]  index;
    logic        final_word;
  } digest_word_t;

  logic [63:0]  chain [8];
  logic [63:0]  blk [16];
  int unsigned  fill_bytes;
  logic [127:0] bit_count;
  digest_word_t digest_q[$];

  function automatic logic [63:0] rotr(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress();
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 80; i++)
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 1) ^ rotr(w[i-15], 8) ^ (w[i-15] >> 7))
           + (rotr(w[i-2], 19) ^ rotr(w[i-2], 61) ^ (w[i-2] >> 6));
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 80; i++) begin
      t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[i] + w[i];
      t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic restart();
    for (int i = 0; i < 8; i++) chain[i] = IV_TABLE[i];
    for (int i = 0; i < 16; i++) blk[i] = '0;
    fill_bytes = 0;
    bit_count = '0;
  endtask

  task automatic absorb_beat(logic [63:0] word, logic [3:0] nbytes, logic is_last);
    int unsigned nb, pos;
    logic [63:0]  keep;
    logic [127:0] total;
    digest_word_t d;
    if (!is_last) begin
      blk[fill_bytes / 8] = word;
      fill_bytes += 8;
      if (fill_bytes >= 128) begin
        compress();
        bit_count += 128'd1024;
        fill_bytes = 0;
      end
      return;
    end
    nb = (nbytes > 8) ? 8 : nbytes;
    keep = (nb == 0) ? 64'd0 : ~(64'hffff_ffff_ffff_ffff >> (8 * nb));
    if (nb == 8) keep = '1;
    blk[fill_bytes / 8] = word & keep;
    pos = fill_bytes + nb;
    total = bit_count + 128'(pos * 8);
    if (pos >= 128) begin
      compress();
      pos = 0;
    end
    if (pos % 8 == 0) blk[pos / 8] = 64'h80 << 56;
    else blk[pos / 8] |= 64'h80 << (56 - 8 * (pos % 8));
    for (int i = pos / 8 + 1; i < 16; i++) blk[i] = '0;
    if (pos >= 112) begin
      compress();
      for (int i = 0; i < 16; i++) blk[i] = '0;
    end
    blk[14] = total[127:64];
    blk[15] = total[63:0];
    compress();
    for (int i = 0; i < 6; i++) begin
      d.word = chain[i];
      d.index = 3'(i);
      d.final_word = (i == 5);
      digest_q.push_back(d);
    end
    restart();
  endtask

  assign pending_words = digest_q.size();

  always @(posedge clk) begin
    digest_word_t want;
    if (!rst_n) begin
      restart();
      digest_q.delete();
      error_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        absorb_beat(in_tdata[63:0], in_tdata[67:64], in_tlast);
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          if (error_count < 10)
            $display("unexpected digest beat %h idx %0d", out_tdata, out_tuser);
          error_count <= error_count + 1;
        end else begin
          want = digest_q.pop_front();
          if (out_tdata !== want.word || out_tuser !== want.index ||
              out_tlast !== want.final_word) begin
            if (error_count < 10)
              $display("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                       want.word, want.index, want.final_word,
                       out_tdata, out_tuser, out_tlast);
            error_count <= error_count + 1;
          end
        end
      end
    end
  end

endmodule

/* verif/testbench.sv */
module testbench;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;  // message_word, valid_bytes, zeros
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata; // digest_word
  logic [2:0]  out_tuser; // word_index
  logic        out_tlast;
  int          error_count;
  int          pending_words;
  bit          hold_sink;

  sha384_stream_hasher DUT (.*);

  sha384_digest_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sink side: random stalls, one long hold-off when asked
  initial begin
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_sink) begin
        out_tready <= 0;
        repeat (600) @(posedge clk);
        hold_sink = 0;
      end
      out_tready <= (gap_len() == 0) || ($urandom_range(0, 3) != 0 && gap_len() < 4);
      @(posedge clk);
    end
  end

  task automatic send_beat(logic [63:0] word, logic [3:0] nbytes, logic is_last, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {4'd0, nbytes, word};
    in_tlast <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // message of n full words then a last beat with the given byte count
  task automatic send_message(int n, logic [3:0] tail_bytes, bit gaps);
    for (int i = 0; i < n; i++) send_beat(rand64(), 4'($urandom_range(0, 15)), 0, gaps);
    send_beat(rand64(), tail_bytes, 1, gaps);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  initial begin
    int beats;
    int n;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tlast = 0;
    hold_sink = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty message, byte-count extremes, block boundary cases
    send_beat(64'h0, 4'd0, 1, 0);
    send_beat('1, 4'd8, 1, 0);
    send_beat('1, 4'd15, 1, 0);
    send_beat(64'h0123_4567_89ab_cdef, 4'd3, 1, 0);
    send_message(13, 4'd8, 0);   // padding spills into a second block
    send_message(15, 4'd8, 0);   // full block on the last beat
    send_message(15, 4'd0, 0);
    send_message(14, 4'd7, 0);
    drain();

    // back-pressure: hold the sink while further messages back up behind the first digest
    hold_sink = 1;
    send_message(2, 4'd5, 0);
    send_message(1, 4'd1, 0);
    send_message(0, 4'd8, 0);
    drain();

    beats = 0;
    while (beats < 250) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 17);
      send_message(n, 4'($urandom_range(0, 15)), 1);
      beats += n + 1;
      if ($urandom_range(0, 9) == 0) drain();
    end
    drain();
    repeat (300) @(posedge clk);

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/sha384_pkg.sv
hw/rtl/sha384_front.sv
hw/rtl/sha384_back.sv
hw/rtl/sha384_stream_hasher.sv
verif/sha384_digest_checker.sv
verif/testbench.sv
